@@ rtl/rcb_pkg.sv @@
package rcb_pkg;

   localparam int LANES    = 32;
   localparam int LANE_W   = 5;
   localparam int DATA_W   = 64;
   localparam int IDX_W    = 12;
   localparam int POS_W    = 13;
   localparam int WORD_W   = POS_W - LANE_W;
   localparam int COUNT_W  = 2;
   localparam int ACTION_W = 2;

   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic               hit;
      logic [LANE_W-1:0]  hit_lane;
      logic [COUNT_W-1:0] count;
   } word_result_type;

endpackage

@@ rtl/two_bit_refcount_bitmap_top.sv @@
// Two-bit reference count bitmap: 2-bit counts for ENTRIES entries, packed 32 to a
// 64-bit word in one synchronous memory. Lookup and set each read the memory word,
// then give the result or write back the modified word. Find-free reads the word
// holding range_begin and then each following word up to the word holding the first
// free entry (or the last word of the range); one word is scanned per cycle. After
// reset the block clears the memory one word a cycle, during which req_tready stays
// low. A result waiting on rsp holds the block in the final step of the next item
// until it is taken.
module two_bit_refcount_bitmap_top #(
   parameter int ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index[11:0], new_count[13:12], range_begin[26:14], range_end[39:27]
   input  logic [39:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // count_value[1:0], free_position[13:2]
   output logic [15:0] rsp_tdata,
   // found[0]
   output logic        rsp_tuser
);
   import rcb_pkg::*;

   localparam int NWORDS = (ENTRIES + LANES - 1) / LANES;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   state_type state_ff, state_in;

   logic [ACTION_W-1:0] act_ff, act_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [COUNT_W-1:0]  val_ff, val_in;
   logic [POS_W-1:0]    begin_ff, begin_in;
   logic [POS_W-1:0]    end_ff, end_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [WORD_W-1:0]   last_ff, last_in;
   logic [AW-1:0]       clr_ff, clr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]    rsp_pos_ff, rsp_pos_in;

   logic [IDX_W-1:0]    in_idx;
   logic [COUNT_W-1:0]  in_val;
   logic [POS_W-1:0]    in_begin, in_end, in_end_sat, in_end_m1;
   logic [ACTION_W-1:0] in_act;

   logic                req_accept, out_free, idx_ok, in_idx_ok;
   logic                find_empty, find_last, terminal, finish, advance;

   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [DATA_W-1:0]   mem_wdata, mem_rdata, merged_word;
   word_result_type     word_res;

   assign in_idx   = req_tdata[11:0];
   assign in_val   = req_tdata[13:12];
   assign in_begin = req_tdata[26:14];
   assign in_end   = req_tdata[39:27];
   assign in_act   = req_tuser;

   assign in_end_sat = (32'(in_end) > ENTRIES) ? POS_W'(ENTRIES) : in_end;
   assign in_end_m1  = in_end_sat - POS_W'(1);
   assign in_idx_ok  = 32'(in_idx) < ENTRIES;
   assign idx_ok     = 32'(idx_ff) < ENTRIES;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign find_empty = begin_ff >= end_ff;
   assign find_last  = word_ff == last_ff;
   assign terminal   = (act_ff != ACT_FIND) || find_empty || word_res.hit || find_last;
   assign finish     = (state_ff == ST_EXEC) && terminal && out_free;
   assign advance    = (state_ff == ST_EXEC) && !terminal;

   rcb_mem #(
      .DEPTH (NWORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rcb_word u_word (
      .word_data   (mem_rdata),
      .word_idx    (word_ff),
      .range_begin (begin_ff),
      .range_end   (end_ff),
      .lane_sel    (idx_ff[LANE_W-1:0]),
      .new_count   (val_ff),
      .result      (word_res),
      .merged_word (merged_word)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(NWORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (in_act == ACT_FIND) begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(in_begin[POS_W-1:LANE_W]);
               end else if (in_act == ACT_LOOKUP || in_act == ACT_SET) begin
                  mem_re    = in_idx_ok;
                  mem_raddr = AW'(in_idx[IDX_W-1:LANE_W]);
               end
            end
         end
         ST_EXEC: begin
            if (advance) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(word_ff + WORD_W'(1));
            end
            if (finish && act_ff == ACT_SET && idx_ok) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(idx_ff[IDX_W-1:LANE_W]);
               mem_wdata = merged_word;
            end
         end
         default: ;
      endcase
   end

   // item registers and result
   always_comb begin
      act_in       = act_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      begin_in     = begin_ff;
      end_in       = end_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      clr_in       = clr_ff + AW'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (req_accept) begin
         act_in   = in_act;
         idx_in   = in_idx;
         val_in   = in_val;
         begin_in = in_begin;
         end_in   = in_end_sat;
         word_in  = in_begin[POS_W-1:LANE_W];
         last_in  = in_end_m1[POS_W-1:LANE_W];
      end
      if (advance) begin
         word_in = word_ff + WORD_W'(1);
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = '0;
         rsp_found_in = 1'b0;
         rsp_pos_in   = '0;
         if (act_ff == ACT_LOOKUP && idx_ok) begin
            rsp_count_in = word_res.count;
         end else if (act_ff == ACT_FIND && !find_empty && word_res.hit) begin
            rsp_found_in = 1'b1;
            rsp_pos_in   = IDX_W'({word_ff, word_res.hit_lane});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      begin_ff     <= begin_in;
      end_ff       <= end_in;
      word_ff      <= word_in;
      last_ff      <= last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_pos_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

@@ rtl/rcb_mem.sv @@
module rcb_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [rcb_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [rcb_pkg::DATA_W-1:0] rd_data
);
   import rcb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rcb_word.sv @@
module rcb_word (
   input  logic [rcb_pkg::DATA_W-1:0]  word_data,
   input  logic [rcb_pkg::WORD_W-1:0]  word_idx,
   input  logic [rcb_pkg::POS_W-1:0]   range_begin,
   input  logic [rcb_pkg::POS_W-1:0]   range_end,
   input  logic [rcb_pkg::LANE_W-1:0]  lane_sel,
   input  logic [rcb_pkg::COUNT_W-1:0] new_count,
   output rcb_pkg::word_result_type    result,
   output logic [rcb_pkg::DATA_W-1:0]  merged_word
);
   import rcb_pkg::*;

   logic [LANES-1:0] lane_free;
   logic [POS_W-1:0] lane_pos;

   // count bit 1 sits at the even bit of each pair, count bit 0 at the odd bit
   always_comb begin
      lane_pos  = '0;
      lane_free = '0;
      for (int k = 0; k < LANES; k++) begin
         lane_pos     = {word_idx, LANE_W'(k)};
         lane_free[k] = !(word_data[2*k] | word_data[2*k+1]) &&
                        (lane_pos >= range_begin) && (lane_pos < range_end);
      end
   end

   always_comb begin
      result.hit      = |lane_free;
      result.hit_lane = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (lane_free[k]) begin
            result.hit_lane = LANE_W'(k);
         end
      end
      result.count = {word_data[2*lane_sel], word_data[2*lane_sel+1]};
   end

   always_comb begin
      merged_word = word_data;
      for (int k = 0; k < LANES; k++) begin
         if (lane_sel == LANE_W'(k)) begin
            merged_word[2*k]   = new_count[1];
            merged_word[2*k+1] = new_count[0];
         end
      end
   end

endmodule

@@ rtl/rcb_checker.sv @@
module rcb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[13:2] == 12'd0)
      else $error("free position set without a hit");

   a_found_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == 2'd0)
      else $error("count reported with a find result");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block not quiet after reset");

endmodule

bind two_bit_refcount_bitmap_top rcb_checker u_rcb_checker (.*);

@@ tb/two_bit_refcount_bitmap_top_tb.sv @@
`timescale 1ns / 100ps

module two_bit_refcount_bitmap_top_tb;
   import rcb_pkg::*;

   localparam int ENTRIES       = 4096;
   localparam int WORDS         = (ENTRIES + LANES - 1) / LANES;
   localparam int HOT_WORDS     = 8;
   localparam int HOT_ENTRIES   = HOT_WORDS * LANES;
   localparam int QUIET_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int RANDOM_ITEMS  = 220;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0]   BIT1_MASK  = 64'h5555_5555_5555_5555;
   localparam logic [DATA_W-1:0]   BIT0_MASK  = 64'hAAAA_AAAA_AAAA_AAAA;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [IDX_W-1:0]    entry_index;
      logic [COUNT_W-1:0]  new_count;
      logic [POS_W-1:0]    range_begin;
      logic [POS_W-1:0]    range_end;
   } bitmap_request_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count_value;
      logic               found;
      logic [IDX_W-1:0]   free_position;
   } bitmap_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   logic [DATA_W-1:0] shadow_words [WORDS];
   bitmap_reply_type  pending_replies [$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_off_left = 0;

   two_bit_refcount_bitmap_top #(
      .ENTRIES(ENTRIES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] stored_count(input logic [IDX_W-1:0] idx);
      logic [DATA_W-1:0] w;
      int                pos;
      w   = shadow_words[idx[IDX_W-1:LANE_W]];
      pos = 2 * idx[LANE_W-1:0];
      // count bit 1 sits below count bit 0
      return {w[pos], w[pos+1]};
   endfunction

   function automatic void store_count(input logic [IDX_W-1:0] idx,
                                       input logic [COUNT_W-1:0] cnt);
      int pos;
      pos = 2 * idx[LANE_W-1:0];
      shadow_words[idx[IDX_W-1:LANE_W]][pos]   = cnt[1];
      shadow_words[idx[IDX_W-1:LANE_W]][pos+1] = cnt[0];
   endfunction

   function automatic bit word_saturated(input logic [IDX_W-LANE_W-1:0] word);
      return (shadow_words[word] & BIT1_MASK) == BIT1_MASK
          || (shadow_words[word] & BIT0_MASK) == BIT0_MASK;
   endfunction

   function automatic bitmap_reply_type bitmap_apply(input bitmap_request_type r);
      bitmap_reply_type  rep;
      logic [POS_W-1:0]  scan;
      logic [POS_W-1:0]  limit;
      rep = '0;
      case (r.action)
         ACT_LOOKUP: begin
            if (r.entry_index < ENTRIES)
               rep.count_value = stored_count(r.entry_index);
         end
         ACT_SET: begin
            if (r.entry_index < ENTRIES)
               store_count(r.entry_index, r.new_count);
         end
         ACT_FIND: begin
            limit = (r.range_end > ENTRIES) ? POS_W'(ENTRIES) : r.range_end;
            scan  = r.range_begin;
            while (scan < limit && !rep.found) begin
               // skip an aligned word whose entries all have count bit 1 set, or all have count bit 0 set
               if (scan[LANE_W-1:0] == 0 && word_saturated(scan[IDX_W-1:LANE_W]))
                  scan = scan + POS_W'(LANES);
               else if (stored_count(scan[IDX_W-1:0]) == 0) begin
                  rep.found         = 1'b1;
                  rep.free_position = scan[IDX_W-1:0];
               end else
                  scan = scan + POS_W'(1);
            end
         end
         default: ;
      endcase
      return rep;
   endfunction

   function automatic bitmap_request_type make_request(input logic [ACTION_W-1:0] action,
                                                       input int idx, input int cnt,
                                                       input int first, input int last);
      bitmap_request_type r;
      r.action      = action;
      r.entry_index = IDX_W'(idx);
      r.new_count   = COUNT_W'(cnt);
      r.range_begin = POS_W'(first);
      r.range_end   = POS_W'(last);
      return r;
   endfunction

   function automatic logic [POS_W-1:0] random_bound();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70)
         return POS_W'($urandom_range(HOT_ENTRIES + 64));
      else if (sel < 90)
         return POS_W'($urandom_range(ENTRIES));
      else
         return POS_W'($urandom_range(8191));
   endfunction

   function automatic bitmap_request_type random_request();
      bitmap_request_type r;
      int                 sel;
      sel = $urandom_range(99);
      r.entry_index = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(HOT_ENTRIES - 1))
                                                : IDX_W'($urandom_range(ENTRIES - 1));
      r.new_count   = ($urandom_range(99) < 25) ? COUNT_W'(0)
                                                : COUNT_W'($urandom_range(1, 3));
      r.range_begin = random_bound();
      sel = $urandom_range(99);
      if (sel < 40)
         r.range_end = r.range_begin + POS_W'($urandom_range(64));
      else if (sel < 65)
         r.range_end = POS_W'(ENTRIES);
      else if (sel < 80)
         r.range_end = POS_W'($urandom_range(ENTRIES));
      else
         r.range_end = POS_W'($urandom_range(8191));
      sel = $urandom_range(99);
      if (sel < 30)
         r.action = ACT_SET;
      else if (sel < 55)
         r.action = ACT_LOOKUP;
      else if (sel < 95)
         r.action = ACT_FIND;
      else
         r.action = ACT_UNUSED;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_item(input bitmap_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {r.range_end, r.range_begin, r.new_count, r.entry_index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(bitmap_apply(r));
   endtask

   // Take results and check them.
   always @(posedge clock) begin
      bitmap_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0)
            report_mismatch("result with nothing expected", rsp_tdata, 0);
         else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[1:0] !== want.count_value)
               report_mismatch("count_value", rsp_tdata[1:0], want.count_value);
            if (rsp_tuser !== want.found)
               report_mismatch("found", rsp_tuser, want.found);
            if (rsp_tdata[13:2] !== want.free_position)
               report_mismatch("free_position", rsp_tdata[13:2], want.free_position);
         end
      end
   end

   // Drive the stall pattern; count down a long hold-off first.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("two_bit_refcount_bitmap_top_tb NOT OK");
      $finish;
   end

   task automatic test_lookup_and_set();
      send_item(make_request(ACT_LOOKUP, 0, 0, 0, 0));
      send_item(make_request(ACT_SET, 0, 3, 0, 0));
      send_item(make_request(ACT_SET, 4095, 1, 0, 0));
      send_item(make_request(ACT_SET, 31, 2, 0, 0));
      send_item(make_request(ACT_SET, 1, 1, 0, 0));
      send_item(make_request(ACT_LOOKUP, 0, 0, 0, 0));
      send_item(make_request(ACT_LOOKUP, 4095, 0, 0, 0));
      send_item(make_request(ACT_LOOKUP, 31, 0, 0, 0));
      send_item(make_request(ACT_LOOKUP, 1, 0, 0, 0));
   endtask

   task automatic test_find_bounds();
      send_item(make_request(ACT_FIND, 0, 0, 0, 1));
      send_item(make_request(ACT_FIND, 0, 0, 0, 8191));
      send_item(make_request(ACT_FIND, 0, 0, 4095, 4096));
      send_item(make_request(ACT_FIND, 0, 0, 4095, 8191));
      send_item(make_request(ACT_FIND, 0, 0, 100, 50));
      send_item(make_request(ACT_FIND, 0, 0, 4096, 4096));
      send_item(make_request(ACT_FIND, 0, 0, 8191, 8191));
      send_item(make_request(ACT_SET, 0, 0, 0, 0));
      send_item(make_request(ACT_FIND, 0, 0, 0, 32));
      send_item(make_request(ACT_FIND, 0, 0, 31, 4096));
   endtask

   task automatic test_unused_action();
      send_item(make_request(ACT_UNUSED, 4095, 0, 8191, 8191));
      send_item(make_request(ACT_UNUSED, 31, 3, 0, 4096));
      send_item(make_request(ACT_LOOKUP, 4095, 0, 0, 0));
   endtask

   // Hold the result side off so the block backs up and stalls its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left = HOLD_OFF_LEN;
      repeat (40) send_item(random_request());
   endtask

   // Write a whole word in one of several patterns, then search from its start.
   task automatic fill_word(input int word);
      int mode;
      int hole;
      int cnt;
      mode = $urandom_range(4);
      hole = $urandom_range(LANES - 1);
      for (int lane = 0; lane < LANES; lane++) begin
         case (mode)
            0:       cnt = $urandom_range(2, 3);
            1:       cnt = 2 * $urandom_range(1) + 1;
            2:       cnt = $urandom_range(1, 3);
            3:       cnt = (lane == hole) ? 0 : $urandom_range(1, 3);
            default: cnt = 0;
         endcase
         send_item(make_request(ACT_SET, word * LANES + lane, cnt,
                                $urandom_range(8191), $urandom_range(8191)));
      end
      send_item(make_request(ACT_FIND, 0, 0, word * LANES, $urandom_range(8191)));
   endtask

   task automatic test_random_mix(input int idle_pct, input int stall_pct);
      int sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 4) begin
            fill_word($urandom_range(HOT_WORDS - 1));
            sent += LANES + 1;
         end else begin
            send_item(random_request());
            sent++;
         end
      end
   endtask

   initial begin
      foreach (shadow_words[i]) shadow_words[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_lookup_and_set();
      test_find_bounds();
      test_unused_action();
      test_backpressure();
      test_random_mix(0, 0);
      test_random_mix(80, 0);
      test_random_mix(0, 80);
      test_random_mix(32, 32);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("two_bit_refcount_bitmap_top_tb OK");
      else
         $display("two_bit_refcount_bitmap_top_tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rcb_pkg.sv
rtl/rcb_mem.sv
rtl/rcb_word.sv
rtl/two_bit_refcount_bitmap_top.sv
rtl/rcb_checker.sv
tb/two_bit_refcount_bitmap_top_tb.sv
